@@ rtl/gsip_pkg.sv @@
// Shared types, constants and arithmetic helpers for the grid segment projection.
package gsip_pkg;

  localparam int unsigned IsoFrac = 30;
  localparam logic signed [31:0] Cos30Q30 = 32'sd929887697;
  localparam logic signed [31:0] Sin30Q30 = 32'sd536870912;
  localparam logic signed [31:0] Cos15Q30 = 32'sd1037154959;
  localparam logic signed [31:0] Sin15Q30 = 32'sd277904834;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegXyScale = 3'd0;
  localparam logic [2:0] RegZScale  = 3'd1;
  localparam logic [2:0] RegRotX    = 3'd2;
  localparam logic [2:0] RegRotY    = 3'd3;
  localparam logic [2:0] RegRotZ    = 3'd4;
  localparam logic [2:0] RegIsoView = 3'd5;
  localparam logic [2:0] RegXOffset = 3'd6;
  localparam logic [2:0] RegYOffset = 3'd7;

  // Configuration as seen by the lanes.
  typedef struct packed {
    logic        [11:0] xy_scale;
    logic signed [12:0] z_scale;
    logic        [31:0] rot_x;
    logic        [31:0] rot_y;
    logic        [31:0] rot_z;
    logic               iso_view;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
  } cfg_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = 80'sd2147483647;
    lo = -80'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // Arithmetic shift right rounding toward zero.
  function automatic logic signed [79:0] trunc_shr(input logic signed [79:0] v,
                                                   input int unsigned sh);
    logic signed [79:0] bias;
    bias = v[79] ? ((80'sd1 <<< sh) - 80'sd1) : 80'sd0;
    trunc_shr = (v + bias) >>> sh;
  endfunction

endpackage

@@ rtl/grid_segment_iso_projection.sv @@
// Top level: two endpoint lanes in lock step, a valid pipeline and an output skid stage.
// Throughput: one segment per cycle while the pipeline is not stalled.
// The two lanes each hold a 12-stage pipeline.
// The pipeline advances whenever its last stage is empty or the skid stage can take it.
// Reset (asynchronous, active low) empties the pipeline and sets registers to defaults.
// Output holds while tready is low; input tready falls only when the last stage and the
// skid stage both hold a beat and the output is stalled.
module grid_segment_iso_projection #(
  parameter int unsigned SCREEN_WIDTH   = 1920,
  parameter int unsigned SCREEN_HEIGHT  = 1080,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // col[9:0], row[19:10], height_start[35:20], height_end[51:36], direction[52], zero pad
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96]
  output logic [127:0] m_axis_tdata
);

  localparam int unsigned Depth = 12;

  gsip_pkg::cfg_t cfg;

  gsip_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // Pipeline enable: stall only when the last stage holds data that cannot move.
  logic [Depth-1:0] vld_q;
  logic             skid_full_q;
  logic [127:0]     skid_q;
  logic             en;
  assign en = !(vld_q[Depth-1] && skid_full_q && !m_axis_tready);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  // Endpoint fields.
  logic [10:0] c0, r0, c1, r1;
  assign c0 = {1'b0, s_axis_tdata[9:0]};
  assign r0 = {1'b0, s_axis_tdata[19:10]};
  assign c1 = s_axis_tdata[52] ? c0 : c0 + 11'd1;
  assign r1 = s_axis_tdata[52] ? r0 + 11'd1 : r0;

  logic signed [31:0] ax, ay, bx, by;

  gsip_lane #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
              .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_a (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg), .c_i(c0), .r_i(r0),
    .h_i(s_axis_tdata[35:20]), .sx_o(ax), .sy_o(ay)
  );

  gsip_lane #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
              .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_b (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg), .c_i(c1), .r_i(r1),
    .h_i(s_axis_tdata[51:36]), .sx_o(bx), .sy_o(by)
  );

  // Merge the lanes into one output beat held in the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (!skid_full_q || m_axis_tready) begin
      skid_full_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!skid_full_q || m_axis_tready) && vld_q[Depth-1]) begin
      skid_q <= {by, bx, ay, ax};
    end
  end

  assign m_axis_tvalid = skid_full_q;
  assign m_axis_tdata  = skid_q;

endmodule

@@ rtl/gsip_lane.sv @@
// One endpoint lane: scaling, three rotations, projection and screen offsets, pipelined.
module gsip_lane #(
  parameter int unsigned SCREEN_WIDTH   = 1920,
  parameter int unsigned SCREEN_HEIGHT  = 1080,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  gsip_pkg::cfg_t      cfg_i,
  input  logic         [10:0] c_i,
  input  logic         [10:0] r_i,
  input  logic signed  [15:0] h_i,
  output logic signed  [31:0] sx_o,
  output logic signed  [31:0] sy_o
);

  localparam logic signed [79:0] WTwice = 80'(2 * SCREEN_WIDTH);
  localparam logic signed [79:0] HQuart = 80'(SCREEN_HEIGHT / 4);

  // Stage 1: scale the coordinates.
  logic signed [31:0] x1_q, y1_q, z1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= $signed({1'b0, c_i}) * $signed({1'b0, cfg_i.xy_scale});
      y1_q <= $signed({1'b0, r_i}) * $signed({1'b0, cfg_i.xy_scale});
      z1_q <= 32'(h_i * cfg_i.z_scale);
    end
  end

  // Rotation products: a' = (a*c - b*s) >> F, b' = (a*s + b*c) >> F.
  function automatic logic signed [15:0] cosw(input logic [31:0] w);
    cosw = w[31:16];
  endfunction
  function automatic logic signed [15:0] sinw(input logic [31:0] w);
    sinw = w[15:0];
  endfunction

  // Stage 2a: products for the x rotation, on (y,z).
  logic signed [47:0] p2_ac_q, p2_bs_q, p2_as_q, p2_bc_q;
  logic signed [31:0] x2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_ac_q <= y1_q * cosw(cfg_i.rot_x);
      p2_bs_q <= z1_q * sinw(cfg_i.rot_x);
      p2_as_q <= y1_q * sinw(cfg_i.rot_x);
      p2_bc_q <= z1_q * cosw(cfg_i.rot_x);
      x2_q    <= x1_q;
    end
  end

  // Stage 2b: combine.
  logic signed [31:0] x3_q, y3_q, z3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q <= x2_q;
      y3_q <= gsip_pkg::sat32(gsip_pkg::trunc_shr(80'(p2_ac_q) - 80'(p2_bs_q),
                                                   COEF_FRAC_BITS));
      z3_q <= gsip_pkg::sat32(gsip_pkg::trunc_shr(80'(p2_as_q) + 80'(p2_bc_q),
                                                   COEF_FRAC_BITS));
    end
  end

  // Stage 3a: products for the y rotation, on (x,z).
  logic signed [47:0] p3_ac_q, p3_bs_q, p3_as_q, p3_bc_q;
  logic signed [31:0] y4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p3_ac_q <= x3_q * cosw(cfg_i.rot_y);
      p3_bs_q <= z3_q * sinw(cfg_i.rot_y);
      p3_as_q <= x3_q * sinw(cfg_i.rot_y);
      p3_bc_q <= z3_q * cosw(cfg_i.rot_y);
      y4_q    <= y3_q;
    end
  end

  logic signed [31:0] x5_q, y5_q, z5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y5_q <= y4_q;
      x5_q <= gsip_pkg::sat32(gsip_pkg::trunc_shr(80'(p3_ac_q) - 80'(p3_bs_q),
                                                   COEF_FRAC_BITS));
      z5_q <= gsip_pkg::sat32(gsip_pkg::trunc_shr(80'(p3_as_q) + 80'(p3_bc_q),
                                                   COEF_FRAC_BITS));
    end
  end

  // Stage 4a: products for the z rotation, on (x,y).
  logic signed [47:0] p4_ac_q, p4_bs_q, p4_as_q, p4_bc_q;
  logic signed [31:0] z6_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p4_ac_q <= x5_q * cosw(cfg_i.rot_z);
      p4_bs_q <= y5_q * sinw(cfg_i.rot_z);
      p4_as_q <= x5_q * sinw(cfg_i.rot_z);
      p4_bc_q <= y5_q * cosw(cfg_i.rot_z);
      z6_q    <= z5_q;
    end
  end

  logic signed [31:0] x7_q, y7_q, z7_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z7_q <= z6_q;
      x7_q <= gsip_pkg::sat32(gsip_pkg::trunc_shr(80'(p4_ac_q) - 80'(p4_bs_q),
                                                   COEF_FRAC_BITS));
      y7_q <= gsip_pkg::sat32(gsip_pkg::trunc_shr(80'(p4_as_q) + 80'(p4_bc_q),
                                                   COEF_FRAC_BITS));
    end
  end

  // Stage 5: isometric sum and difference, with the angle constants.
  logic signed [32:0] dif8_q, sum8_q;
  logic signed [31:0] z8_q, kc8_q, ks8_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dif8_q <= 33'(x7_q) - 33'(y7_q);
      sum8_q <= 33'(x7_q) + 33'(y7_q);
      z8_q   <= z7_q;
      kc8_q  <= cfg_i.iso_view ? gsip_pkg::Cos15Q30 : gsip_pkg::Cos30Q30;
      ks8_q  <= cfg_i.iso_view ? gsip_pkg::Sin15Q30 : gsip_pkg::Sin30Q30;
    end
  end

  // Stage 6: projection products.
  logic signed [64:0] px9_q, py9_q;
  logic signed [31:0] z9_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px9_q <= dif8_q * kc8_q;
      py9_q <= sum8_q * ks8_q;
      z9_q  <= z8_q;
    end
  end

  // Stage 7: scale back, subtract z from y and add the user offsets, plus H/4 on y.
  logic signed [33:0] sxo10_q;
  logic signed [31:0] sy10_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sxo10_q <= 34'(gsip_pkg::sat32(gsip_pkg::trunc_shr(80'(px9_q), gsip_pkg::IsoFrac)))
                 + 34'(cfg_i.x_offset);
      sy10_q  <= gsip_pkg::sat32(gsip_pkg::sat32(gsip_pkg::trunc_shr(
                   80'(py9_q) - (80'(z9_q) <<< gsip_pkg::IsoFrac), gsip_pkg::IsoFrac))
                 + 80'(cfg_i.y_offset) + HQuart);
    end
  end

  // Stage 8: x gets W/2.5 as (5n + 2W)/5; register the sign and magnitude of the numerator.
  // The magnitude stays below 2^34, so it fits the reciprocal multiply that follows.
  logic signed [39:0] num;
  logic        [33:0] mag11_q;
  logic               neg11_q;
  logic signed [31:0] sy11_q;
  always_comb begin
    num = 40'(sxo10_q) * 40'sd5 + 40'(WTwice);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg11_q <= num[39];
      mag11_q <= num[39] ? 34'(-num) : 34'(num);
      sy11_q  <= sy10_q;
    end
  end

  // Stage 9: divide by five through a reciprocal multiply, truncating toward zero.
  logic        [31:0] quo;
  logic signed [79:0] qs;
  always_comb begin
    quo = 32'((68'(mag11_q) * 68'd3435973837) >> 34);
    qs  = neg11_q ? -80'(quo) : 80'(quo);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_o <= gsip_pkg::sat32(qs);
      sy_o <= sy11_q;
    end
  end

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

@@ rtl/gsip_cfg.sv @@
// APB-style register file for the projection settings.
module gsip_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output gsip_pkg::cfg_t cfg_o
);

  gsip_pkg::cfg_t cfg_q;
  logic [2:0] idx;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xy_scale <= 12'd1;
      cfg_q.z_scale  <= 13'sd1;
      cfg_q.rot_x    <= 32'd16384;
      cfg_q.rot_y    <= 32'd16384;
      cfg_q.rot_z    <= 32'd16384;
      cfg_q.iso_view <= 1'b0;
      cfg_q.x_offset <= '0;
      cfg_q.y_offset <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        gsip_pkg::RegXyScale: cfg_q.xy_scale <= pwdata[11:0];
        gsip_pkg::RegZScale:  cfg_q.z_scale  <= pwdata[12:0];
        gsip_pkg::RegRotX:    cfg_q.rot_x    <= pwdata;
        gsip_pkg::RegRotY:    cfg_q.rot_y    <= pwdata;
        gsip_pkg::RegRotZ:    cfg_q.rot_z    <= pwdata;
        gsip_pkg::RegIsoView: cfg_q.iso_view <= pwdata[0];
        gsip_pkg::RegXOffset: cfg_q.x_offset <= pwdata[15:0];
        gsip_pkg::RegYOffset: cfg_q.y_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      gsip_pkg::RegXyScale: prdata = 32'(cfg_q.xy_scale);
      gsip_pkg::RegZScale:  prdata = 32'(unsigned'(cfg_q.z_scale));
      gsip_pkg::RegRotX:    prdata = cfg_q.rot_x;
      gsip_pkg::RegRotY:    prdata = cfg_q.rot_y;
      gsip_pkg::RegRotZ:    prdata = cfg_q.rot_z;
      gsip_pkg::RegIsoView: prdata = 32'(cfg_q.iso_view);
      gsip_pkg::RegXOffset: prdata = 32'(unsigned'(cfg_q.x_offset));
      gsip_pkg::RegYOffset: prdata = 32'(unsigned'(cfg_q.y_offset));
      default:              prdata = '0;
    endcase
  end

endmodule

@@ rtl/gsip_checker.sv @@
// Port-level checker for the projection block, bound to the top level.
module gsip_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         pready
);

  // A stalled output beat keeps its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // Input is only refused while an output beat waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without output stall");

  // The register port never waits.
  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind grid_segment_iso_projection gsip_checker u_gsip_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .pready
);
